// File: hw/rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Types and codes shared by the positional list engine and its cells.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

  localparam int VAL_W = 32;
  localparam int POS_W = 7;
  localparam int OPC_W = 4;
  localparam int STS_W = 2;

  localparam logic [OPC_W-1:0] OP_INS_HEAD = 4'd0;
  localparam logic [OPC_W-1:0] OP_INS_TAIL = 4'd1;
  localparam logic [OPC_W-1:0] OP_INS_AT   = 4'd2;
  localparam logic [OPC_W-1:0] OP_READ_AT  = 4'd3;
  localparam logic [OPC_W-1:0] OP_DEL_HEAD = 4'd4;
  localparam logic [OPC_W-1:0] OP_DEL_TAIL = 4'd5;
  localparam logic [OPC_W-1:0] OP_DEL_AT   = 4'd6;
  localparam logic [OPC_W-1:0] OP_CLEAR    = 4'd7;
  localparam logic [OPC_W-1:0] OP_LIST     = 4'd8;

  localparam logic [STS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STS_W-1:0] ST_EMPTY  = 2'd1;
  localparam logic [STS_W-1:0] ST_BADPOS = 2'd2;
  localparam logic [STS_W-1:0] ST_FULL   = 2'd3;

  // What every cell of the chain does on a command.
  typedef enum logic [1:0] {
    CH_HOLD,
    CH_INSERT,
    CH_DELETE,
    CH_ROTATE
  } chain_op_t;

  typedef struct packed {
    chain_op_t         op;
    logic [POS_W-1:0]  idx;    // insert/delete slot
    logic [POS_W-1:0]  last;   // tail slot for rotate
    logic [VAL_W-1:0]  value;  // inserted value, or head value on rotate
  } chain_cmd_t;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } ple_state_t;

endpackage

`default_nettype wire

// File: hw/rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed 32-bit values held in a shifting chain of cells.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_stall with opcode, position and item_value.
//   Results leave on out_valid/out_stall with status, read_value, list_length
//   and last_of_run. A beat moves when valid is high and stall is low.
//   Every edit (insert, delete, clear) and every read is taken as one step:
//   all cells shift together, so the result is registered in the cycle after
//   the request beat, and unless the receiver stalls a new request can follow
//   in the next cycle. List all on a non-empty list first takes the request,
//   then gives one beat per element while the receiver does not stall, the
//   chain rotating one slot per beat and the head emitted and moved to the tail.
//   After length beats it is back in order. in_stall stays high in the run.
//   If the receiver stalls, the result register holds its beat and in_stall
//   rises, so no request is taken until the beat leaves.
//   Reset (rst, synchronous) empties the list and drops any pending result;
//   cell contents are not cleared and are never shown before being written.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_engine
  import ple_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [OPC_W-1:0]        opcode,
  input  logic [POS_W-1:0]        position,
  input  logic signed [VAL_W-1:0] item_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [STS_W-1:0]        status,
  output logic signed [VAL_W-1:0] read_value,
  output logic [POS_W-1:0]        list_length,
  output logic                    last_of_run
);

  localparam int LW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  logic [VAL_W-1:0] cell_q [DEPTH];

  ple_state_t       state, state_next;
  logic [LW-1:0]    len, len_next;
  logic [LW-1:0]    remain, remain_next;
  chain_cmd_t       cmd;

  logic             take_out;
  logic             accept;
  logic             emit;
  logic [STS_W-1:0] res_status;
  logic [VAL_W-1:0] res_value;
  logic             res_last;

  logic [POS_W-1:0] len7;
  logic [POS_W-1:0] pos_m1;
  logic [POS_W-1:0] tail7;
  logic [IW-1:0]    pos_sel;
  logic [IW-1:0]    tail_sel;
  logic             pos_ok;
  logic             is_empty;
  logic             is_full;

  // ---- chain of cells ------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] prev_v, next_v;
    if (i == 0) begin : g_first
      assign prev_v = '0;
    end else begin : g_mid_p
      assign prev_v = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_v = '0;
    end else begin : g_mid_n
      assign next_v = cell_q[i+1];
    end
    ple_cell #(.INDEX(i)) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .prev_value (prev_v),
      .next_value (next_v),
      .value      (cell_q[i])
    );
  end

  // ---- handshake -----------------------------------------------------------
  assign take_out = !out_valid || !out_stall;
  assign in_stall = (state == S_LIST) || !take_out;
  assign accept   = in_valid && !in_stall;

  assign len7     = POS_W'(len);
  assign pos_m1   = position - POS_W'(1);
  assign tail7    = len7 - POS_W'(1);
  assign pos_sel  = pos_m1[IW-1:0];
  assign tail_sel = tail7[IW-1:0];
  assign pos_ok   = (position != '0) && (position <= len7);
  assign is_empty = (len == '0);
  assign is_full  = (len7 == POS_W'(DEPTH));

  // ---- next state ----------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && opcode == OP_LIST && !is_empty) begin
          state_next = S_LIST;
        end
      end
      S_LIST: begin
        if (take_out && remain == LW'(1)) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // ---- request decode and chain command ------------------------------------
  always_comb begin
    emit        = 1'b0;
    res_status  = ST_OK;
    res_value   = '0;
    res_last    = 1'b1;
    len_next    = len;
    remain_next = remain;
    cmd         = '{op: CH_HOLD, idx: '0, last: '0, value: '0};

    if (state == S_LIST) begin
      if (take_out) begin
        emit        = 1'b1;
        res_value   = cell_q[0];
        res_last    = (remain == LW'(1));
        remain_next = remain - LW'(1);
        cmd         = '{op: CH_ROTATE, idx: '0, last: tail7, value: cell_q[0]};
      end
    end else if (accept) begin
      emit = 1'b1;
      unique case (opcode)
        OP_INS_HEAD, OP_INS_TAIL: begin
          if (is_full) begin
            res_status = ST_FULL;
          end else begin
            cmd = '{op: CH_INSERT, idx: (opcode == OP_INS_HEAD) ? '0 : len7,
                    last: '0, value: item_value};
            len_next = len + LW'(1);
          end
        end
        OP_INS_AT: begin
          priority if (is_empty) begin
            res_status = ST_EMPTY;
          end else if (!pos_ok) begin
            res_status = ST_BADPOS;
          end else if (is_full) begin
            res_status = ST_FULL;
          end else begin
            cmd      = '{op: CH_INSERT, idx: pos_m1, last: '0, value: item_value};
            len_next = len + LW'(1);
          end
        end
        OP_READ_AT: begin
          priority if (is_empty) begin
            res_status = ST_EMPTY;
          end else if (!pos_ok) begin
            res_status = ST_BADPOS;
          end else begin
            res_value = cell_q[pos_sel];
          end
        end
        OP_DEL_HEAD: begin
          if (is_empty) begin
            res_status = ST_EMPTY;
          end else begin
            res_value = cell_q[0];
            cmd       = '{op: CH_DELETE, idx: '0, last: '0, value: '0};
            len_next  = len - LW'(1);
          end
        end
        OP_DEL_TAIL: begin
          if (is_empty) begin
            res_status = ST_EMPTY;
          end else begin
            res_value = cell_q[tail_sel];
            cmd       = '{op: CH_DELETE, idx: tail7, last: '0, value: '0};
            len_next  = len - LW'(1);
          end
        end
        OP_DEL_AT: begin
          priority if (is_empty) begin
            res_status = ST_EMPTY;
          end else if (!pos_ok) begin
            res_status = ST_BADPOS;
          end else begin
            res_value = cell_q[pos_sel];
            cmd       = '{op: CH_DELETE, idx: pos_m1, last: '0, value: '0};
            len_next  = len - LW'(1);
          end
        end
        OP_CLEAR: begin
          len_next = '0;
        end
        OP_LIST: begin
          if (is_empty) begin
            res_status = ST_EMPTY;
          end else begin
            // beats come from the rotate run
            emit        = 1'b0;
            remain_next = len;
          end
        end
        default: begin
          res_status = ST_OK;
        end
      endcase
    end
  end

  // ---- registers -----------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      remain    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      len    <= len_next;
      remain <= remain_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      status      <= res_status;
      read_value  <= res_value;
      list_length <= POS_W'(len_next);
      last_of_run <= res_last;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One slot of the list chain: loads, takes a neighbor's value, or holds.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_cell
  import ple_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic             clk,
  input  chain_cmd_t       cmd,
  input  logic [VAL_W-1:0] prev_value,
  input  logic [VAL_W-1:0] next_value,
  output logic [VAL_W-1:0] value
);

  localparam logic [POS_W-1:0] MyIdx = POS_W'(INDEX);

  logic [VAL_W-1:0] value_next;

  always_comb begin
    value_next = value;
    unique case (cmd.op)
      CH_HOLD: value_next = value;
      CH_INSERT: begin
        if (MyIdx == cmd.idx) begin
          value_next = cmd.value;
        end else if (MyIdx > cmd.idx) begin
          value_next = prev_value;
        end
      end
      CH_DELETE: begin
        if (MyIdx >= cmd.idx) begin
          value_next = next_value;
        end
      end
      CH_ROTATE: begin
        // head wraps around to the tail slot
        if (MyIdx < cmd.last) begin
          value_next = next_value;
        end else if (MyIdx == cmd.last) begin
          value_next = cmd.value;
        end
      end
      default: value_next = value;
    endcase
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

`default_nettype wire

// File: hw/rtl/ple_checker.sv
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks for the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_checker
  import ple_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [STS_W-1:0]        status,
  input logic signed [VAL_W-1:0] read_value,
  input logic [POS_W-1:0]        list_length,
  input logic                    last_of_run
);

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(read_value) &&
      $stable(status) && $stable(list_length) && $stable(last_of_run))
    else $error("result beat changed while stalled");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> list_length <= POS_W'(DEPTH))
    else $error("list length above depth");

  a_err_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> last_of_run)
    else $error("error status on a multi-beat run");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> list_length == POS_W'(DEPTH))
    else $error("full status with list not full");

  // mid-run beat leaves the request side blocked
  a_run_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_of_run |-> in_stall)
    else $error("request taken during a list run");

endmodule

bind positional_list_engine ple_checker #(.DEPTH(DEPTH)) u_ple_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .read_value  (read_value),
  .list_length (list_length),
  .last_of_run (last_of_run)
);

`default_nettype wire
